[rtl/core/ccdr_pkg.sv]
// Shared types, constants and arithmetic helpers for the cross-coupled delay reverb.
package ccdr_pkg;

    localparam int LINE_DEPTH  = 8192;
    localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
    localparam int LEN_BITS    = ADDR_BITS + 1;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int COEF_FRAC   = 15;
    localparam int OPND_BITS   = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = 2 * OPND_BITS;
    localparam int TERM_BITS   = PROD_BITS - COEF_FRAC;
    localparam int ACC_BITS    = TERM_BITS + 1;
    localparam int CFG_IDX_BITS = 3;

    // right length = len * 25 / 28 = ((len * 25) >> 2) / 7, the divide by 7 done by reciprocal
    localparam int RIGHT_NUM    = 25;
    localparam int RIGHT_DEN    = 28;
    localparam int PRE_SHIFT    = 2;
    localparam int RECIP_DEN    = RIGHT_DEN / (2 ** PRE_SHIFT);
    localparam int RECIP_SHIFT  = 19;
    localparam int RECIP_MUL    = (2 ** RECIP_SHIFT + RECIP_DEN - 1) / RECIP_DEN;
    localparam int SCALED_BITS  = LEN_BITS + 5;
    localparam int QUOT_BITS    = SCALED_BITS - PRE_SHIFT;
    localparam int RECIP_BITS   = $clog2(RECIP_MUL + 1);
    localparam int RPROD_BITS   = QUOT_BITS + RECIP_BITS;

    localparam int SAT_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAT_MIN = -(2 ** (SAMPLE_BITS - 1));

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [OPND_BITS-1:0]   opnd_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [TERM_BITS-1:0]   term_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;
    typedef logic [LEN_BITS-1:0]           len_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DELAY_LENGTH   = 3'd0,
        CFG_FEEDBACK_COEF  = 3'd1,
        CFG_CROSSOVER_COEF = 3'd2,
        CFG_OUTPUT_GAIN    = 3'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_MOD,
        OP_LEFT,
        OP_CROSS,
        OP_RIGHT,
        OP_READ,
        OP_SUM,
        OP_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } sts_t;

    // Q1.15 x Q1.15 product back to a Q4.15 term, floor rounding
    function automatic term_t qshift(prod_t p);
        return p[PROD_BITS-1:COEF_FRAC];
    endfunction

    function automatic sample_t sat_word(acc_t v);
        sample_t r;
        if (v > acc_t'(SAT_MAX))
            r = sample_t'(SAT_MAX);
        else if (v < acc_t'(SAT_MIN))
            r = sample_t'(SAT_MIN);
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

endpackage

[rtl/core/ccdr_ctrl.sv]
// Sequencer for the reverb: clearing pass, per-word step order and output handshake.
module ccdr_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output ccdr_pkg::cmd_t cmd,
    input  ccdr_pkg::sts_t sts
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MOD   = 9'b000000100,
        S_LEFT  = 9'b000001000,
        S_CROSS = 9'b000010000,
        S_RIGHT = 9'b000100000,
        S_READ  = 9'b001000000,
        S_SUM   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = ccdr_pkg::OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = ccdr_pkg::OP_CLEAR;
                if (sts.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = ccdr_pkg::OP_ACCEPT;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.op     = ccdr_pkg::OP_MOD;
                state_next = S_LEFT;
            end
            S_LEFT:
            begin
                cmd.op     = ccdr_pkg::OP_LEFT;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                cmd.op     = ccdr_pkg::OP_CROSS;
                state_next = S_RIGHT;
            end
            S_RIGHT:
            begin
                cmd.op     = ccdr_pkg::OP_RIGHT;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.op     = ccdr_pkg::OP_READ;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op     = ccdr_pkg::OP_SUM;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op     = ccdr_pkg::OP_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign load = (cmd.op == ccdr_pkg::OP_LOAD);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_starts_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_MOD))
        else $error("accepted word did not start processing");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output valid raised outside output step");

    a_no_output_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !out_valid_reg)
        else $error("output valid during clearing pass");

    a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || !out_stall))
        else $error("pending output word overwritten");

endmodule

[rtl/core/ccdr_datapath.sv]
// Reverb datapath: config registers, both delay line memories, two multipliers, indices.
module ccdr_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ccdr_pkg::cmd_t                         cmd,
    output ccdr_pkg::sts_t                         sts,
    input  logic signed [ccdr_pkg::SAMPLE_BITS-1:0] in_sample,
    input  logic signed [ccdr_pkg::SAMPLE_BITS-1:0] mod_sample,
    output logic signed [ccdr_pkg::SAMPLE_BITS-1:0] out_sample,
    input  logic                                   cfg_we,
    input  logic [ccdr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [ccdr_pkg::COEF_BITS-1:0]          cfg_data
);

    ccdr_pkg::sample_t left_mem  [ccdr_pkg::LINE_DEPTH];
    ccdr_pkg::sample_t right_mem [ccdr_pkg::LINE_DEPTH];

    ccdr_pkg::len_t                          delay_length_reg;
    logic signed [ccdr_pkg::COEF_BITS-1:0]   feedback_coef_reg;
    logic signed [ccdr_pkg::COEF_BITS-1:0]   crossover_coef_reg;
    logic [ccdr_pkg::COEF_BITS-1:0]          output_gain_reg;

    ccdr_pkg::len_t                          len1_reg;
    ccdr_pkg::len_t                          len1_next;
    logic [ccdr_pkg::QUOT_BITS-1:0]          quot_reg;
    logic [ccdr_pkg::SCALED_BITS-1:0]        scaled;
    ccdr_pkg::len_t                          len2_reg;
    ccdr_pkg::len_t                          len2_next;
    logic [ccdr_pkg::RPROD_BITS-1:0]         rprod;

    ccdr_pkg::addr_t   li_reg, li_next;
    ccdr_pkg::addr_t   ri_reg, ri_next;
    ccdr_pkg::addr_t   clr_addr_reg;
    ccdr_pkg::len_t    li_inc, ri_inc;

    ccdr_pkg::sample_t x_reg;
    ccdr_pkg::sample_t fbm_reg, com_reg, l_reg;
    ccdr_pkg::sample_t fbm_now, com_now;
    ccdr_pkg::sample_t left_rd_reg, right_rd_reg;
    ccdr_pkg::sample_t line_sum;
    ccdr_pkg::sample_t out_sample_reg;
    ccdr_pkg::prod_t   pa_reg, pb_reg;
    ccdr_pkg::prod_t   pa_next, pb_next;
    ccdr_pkg::opnd_t   a_op1, a_op2, b_op1, b_op2;
    ccdr_pkg::opnd_t   pair_sum;

    logic              rd_en;
    logic              left_we, right_we;
    ccdr_pkg::addr_t   left_waddr, right_waddr;
    ccdr_pkg::sample_t left_wdata, right_wdata;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg   <= ccdr_pkg::LEN_BITS'(1638);
            feedback_coef_reg  <= 16'sd6554;
            crossover_coef_reg <= 16'sd6554;
            output_gain_reg    <= 16'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ccdr_pkg::CFG_DELAY_LENGTH:
                    delay_length_reg <= cfg_data[ccdr_pkg::LEN_BITS-1:0];
                ccdr_pkg::CFG_FEEDBACK_COEF:
                    feedback_coef_reg <= $signed(cfg_data);
                ccdr_pkg::CFG_CROSSOVER_COEF:
                    crossover_coef_reg <= $signed(cfg_data);
                ccdr_pkg::CFG_OUTPUT_GAIN:
                    output_gain_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // line lengths, registered from delay_length_reg into len1_reg and quot_reg, then len2_reg
    always_comb
    begin
        if (delay_length_reg == '0)
            len1_next = ccdr_pkg::LEN_BITS'(1);
        else if (delay_length_reg > ccdr_pkg::LEN_BITS'(ccdr_pkg::LINE_DEPTH))
            len1_next = ccdr_pkg::LEN_BITS'(ccdr_pkg::LINE_DEPTH);
        else
            len1_next = delay_length_reg;
        scaled = ccdr_pkg::SCALED_BITS'(len1_next) *
                 ccdr_pkg::SCALED_BITS'(ccdr_pkg::RIGHT_NUM);
        rprod = ccdr_pkg::RPROD_BITS'(quot_reg) *
                ccdr_pkg::RPROD_BITS'(ccdr_pkg::RECIP_MUL);
        len2_next = ccdr_pkg::LEN_BITS'(rprod >> ccdr_pkg::RECIP_SHIFT);
        if (len2_next == '0)
            len2_next = ccdr_pkg::LEN_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        len1_reg <= len1_next;
        quot_reg <= scaled[ccdr_pkg::SCALED_BITS-1:ccdr_pkg::PRE_SHIFT];
        len2_reg <= len2_next;
    end

    // index advance
    always_comb
    begin
        li_inc  = ccdr_pkg::LEN_BITS'(li_reg) + ccdr_pkg::LEN_BITS'(1);
        ri_inc  = ccdr_pkg::LEN_BITS'(ri_reg) + ccdr_pkg::LEN_BITS'(1);
        li_next = (li_inc >= len1_reg) ? '0 : li_inc[ccdr_pkg::ADDR_BITS-1:0];
        ri_next = (ri_inc >= len2_reg) ? '0 : ri_inc[ccdr_pkg::ADDR_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            li_reg       <= '0;
            ri_reg       <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.op == ccdr_pkg::OP_RIGHT)
            begin
                li_reg <= li_next;
                ri_reg <= ri_next;
            end
            if (cmd.op == ccdr_pkg::OP_CLEAR)
                clr_addr_reg <= clr_addr_reg + ccdr_pkg::ADDR_BITS'(1);
        end
    end

    assign sts.clear_last = (cmd.op == ccdr_pkg::OP_CLEAR) &&
                            (clr_addr_reg == ccdr_pkg::ADDR_BITS'(ccdr_pkg::LINE_DEPTH - 1));

    // arithmetic
    assign fbm_now = ccdr_pkg::sat_word(ccdr_pkg::acc_t'(ccdr_pkg::qshift(pa_reg)));
    assign com_now = ccdr_pkg::sat_word(ccdr_pkg::acc_t'(ccdr_pkg::qshift(pb_reg)));
    assign line_sum = ccdr_pkg::sat_word(ccdr_pkg::acc_t'(ccdr_pkg::qshift(pa_reg)) +
                                         ccdr_pkg::acc_t'(ccdr_pkg::qshift(pb_reg)) +
                                         ccdr_pkg::acc_t'(x_reg));
    assign pair_sum = ccdr_pkg::opnd_t'(left_rd_reg) + ccdr_pkg::opnd_t'(right_rd_reg);

    always_comb
    begin
        a_op1 = '0;
        a_op2 = '0;
        b_op1 = '0;
        b_op2 = '0;
        rd_en = 1'b0;
        unique case (cmd.op)
            ccdr_pkg::OP_ACCEPT:
            begin
                a_op1 = ccdr_pkg::opnd_t'(feedback_coef_reg);
                a_op2 = ccdr_pkg::opnd_t'(mod_sample);
                b_op1 = ccdr_pkg::opnd_t'(crossover_coef_reg);
                b_op2 = ccdr_pkg::opnd_t'(mod_sample);
                rd_en = 1'b1;
            end
            ccdr_pkg::OP_MOD:
            begin
                a_op1 = ccdr_pkg::opnd_t'(left_rd_reg);
                a_op2 = ccdr_pkg::opnd_t'(fbm_now);
                b_op1 = ccdr_pkg::opnd_t'(right_rd_reg);
                b_op2 = ccdr_pkg::opnd_t'(com_now);
            end
            ccdr_pkg::OP_LEFT:
            begin
                a_op1 = ccdr_pkg::opnd_t'(right_rd_reg);
                a_op2 = ccdr_pkg::opnd_t'(fbm_reg);
            end
            ccdr_pkg::OP_CROSS:
            begin
                b_op1 = ccdr_pkg::opnd_t'(l_reg);
                b_op2 = ccdr_pkg::opnd_t'(com_reg);
            end
            ccdr_pkg::OP_READ:
            begin
                rd_en = 1'b1;
            end
            ccdr_pkg::OP_SUM:
            begin
                a_op1 = pair_sum;
                a_op2 = $signed({1'b0, output_gain_reg});
            end
            ccdr_pkg::OP_NONE,
            ccdr_pkg::OP_CLEAR,
            ccdr_pkg::OP_RIGHT,
            ccdr_pkg::OP_LOAD:
            begin
            end
            default:
            begin
            end
        endcase
        pa_next = a_op1 * a_op2;
        pb_next = b_op1 * b_op2;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            ccdr_pkg::OP_ACCEPT:
            begin
                x_reg  <= in_sample;
                pa_reg <= pa_next;
                pb_reg <= pb_next;
            end
            ccdr_pkg::OP_MOD:
            begin
                fbm_reg <= fbm_now;
                com_reg <= com_now;
                pa_reg  <= pa_next;
                pb_reg  <= pb_next;
            end
            ccdr_pkg::OP_LEFT:
            begin
                l_reg  <= line_sum;
                pa_reg <= pa_next;
            end
            ccdr_pkg::OP_CROSS:
            begin
                pb_reg <= pb_next;
            end
            ccdr_pkg::OP_SUM:
            begin
                pa_reg <= pa_next;
            end
            ccdr_pkg::OP_LOAD:
            begin
                out_sample_reg <= ccdr_pkg::sat_word(ccdr_pkg::acc_t'(ccdr_pkg::qshift(pa_reg)));
            end
            ccdr_pkg::OP_NONE,
            ccdr_pkg::OP_CLEAR,
            ccdr_pkg::OP_RIGHT,
            ccdr_pkg::OP_READ:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // delay line memories
    assign left_we     = (cmd.op == ccdr_pkg::OP_LEFT) || (cmd.op == ccdr_pkg::OP_CLEAR);
    assign right_we    = (cmd.op == ccdr_pkg::OP_RIGHT) || (cmd.op == ccdr_pkg::OP_CLEAR);
    assign left_waddr  = (cmd.op == ccdr_pkg::OP_CLEAR) ? clr_addr_reg : li_reg;
    assign right_waddr = (cmd.op == ccdr_pkg::OP_CLEAR) ? clr_addr_reg : ri_reg;
    assign left_wdata  = (cmd.op == ccdr_pkg::OP_CLEAR) ? '0 : line_sum;
    assign right_wdata = (cmd.op == ccdr_pkg::OP_CLEAR) ? '0 : line_sum;

    always_ff @(posedge clk)
    begin
        if (left_we)
            left_mem[left_waddr] <= left_wdata;
        if (rd_en)
            left_rd_reg <= left_mem[li_reg];
    end

    always_ff @(posedge clk)
    begin
        if (right_we)
            right_mem[right_waddr] <= right_wdata;
        if (rd_en)
            right_rd_reg <= right_mem[ri_reg];
    end

    assign out_sample = out_sample_reg;

endmodule

[rtl/core/cross_coupled_delay_reverb.sv]
// Top level of the cross-coupled feedback delay line reverb.
// After reset the block runs a clearing pass that zeroes every word of both delay
// lines; in_stall stays high until it ends, configuration writes are taken meanwhile.
// Each accepted word steps through MOD, LEFT, CROSS, RIGHT, READ, SUM and OUT to
// the output register, an order set by the single read/write port of each delay line
// memory and the two shared 17x17 multipliers; the next word is accepted only after
// the last is loaded, and a load waits while out_stall holds back a pending word.
// A finished word waits in the output register while the next input word is accepted
// and processed. A delay_length write reaches len1_reg and quot_reg, then len2_reg.
module cross_coupled_delay_reverb
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [ccdr_pkg::SAMPLE_BITS-1:0] in_sample,
    input  logic signed [ccdr_pkg::SAMPLE_BITS-1:0] mod_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [ccdr_pkg::SAMPLE_BITS-1:0] out_sample,
    input  logic                                   cfg_we,
    input  logic [ccdr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [ccdr_pkg::COEF_BITS-1:0]          cfg_data
);

    ccdr_pkg::cmd_t cmd;
    ccdr_pkg::sts_t sts;

    ccdr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    ccdr_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_sample  (in_sample),
        .mod_sample (mod_sample),
        .out_sample (out_sample),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

endmodule
